[rtl/knxrif_pkg.sv]
package knxrif_pkg;

  localparam int SAME_DEST_LIMIT = 5;
  localparam int RUN_W           = 3;
  localparam int ADDR_W          = 16;
  localparam int HOP_W           = 3;
  localparam int PADDR_W         = 6;
  localparam int PDATA_W         = 64;

  typedef enum logic [1:0] {
    ACT_IGNORE_TOTALLY    = 2'd0,
    ACT_IGNORE_ACKED      = 2'd1,
    ACT_FORWARD_LOCALLY   = 2'd2,
    ACT_ROUTE_DECREMENTED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_ROUTE_ALL = 2'd0,
    MODE_BLOCK_ALL = 2'd1,
    MODE_FILTER    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ROUTING_MODE  = 3'd0,
    REG_OWN_ADDRESS   = 3'd1,
    REG_OWN_ADDR_VLD  = 3'd2,
    REG_GROUP_WORD_0  = 3'd3,
    REG_GROUP_WORD_1  = 3'd4,
    REG_GROUP_WORD_2  = 3'd5,
    REG_GROUP_WORD_3  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    action_t          action;
    logic             malformed;
    logic [RUN_W-1:0] count;
    logic             limit_hit;
  } result_t;

endpackage

[rtl/knx_routing_indication_filter.sv]
// KNX coupler routing indication filter.
//
// Input channel (in_valid / in_stall): one routing indication per transfer,
// with batch_start, frame_well_formed, dest_is_group, dest_address and
// hop_count. Output channel (out_valid / out_stall): one result per
// indication, in order: filter_action, malformed, repeat_count and
// repeat_limit_hit.
// Each result is registered: it goes into the output register when that is
// free, else into the skid register.
// Throughput is one indication per cycle while in_stall is low; the decision
// is a few compares, a 256:1 bitmap bit select and a 3-bit counter update, all
// between the input ports and the output register.
// When the receiver stalls, a second result slot (skid register) still takes
// one more indication; in_stall rises only while that slot is occupied and
// falls at the edge at which the output result transfers.
// Configuration goes through the APB port, 64-bit registers at 8*index; the
// user must write it only while no transfer is in flight (the block does not enforce this).
// Synchronous reset clears the configuration registers and the repeat tracking
// state and empties both result slots; no clearing pass is needed.
module knx_routing_indication_filter (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [knxrif_pkg::PADDR_W-1:0]    paddr,
  input  logic [knxrif_pkg::PDATA_W-1:0]    pwdata,
  output logic [knxrif_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  // indication input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              batch_start,
  input  logic                              frame_well_formed,
  input  logic                              dest_is_group,
  input  logic [knxrif_pkg::ADDR_W-1:0]     dest_address,
  input  logic [knxrif_pkg::HOP_W-1:0]      hop_count,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        filter_action,
  output logic                              malformed,
  output logic [knxrif_pkg::RUN_W-1:0]      repeat_count,
  output logic                              repeat_limit_hit
);

  localparam int RW = knxrif_pkg::RUN_W;

  // ---------------- configuration registers ----------------
  logic [1:0]                     routing_mode;
  logic [knxrif_pkg::ADDR_W-1:0]  own_address;
  logic                           own_address_valid;
  logic [63:0]                    group_word [4];

  logic       cfg_write;
  logic [2:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      routing_mode      <= knxrif_pkg::MODE_ROUTE_ALL;
      own_address       <= '0;
      own_address_valid <= 1'b0;
      for (int i = 0; i < 4; i++) group_word[i] <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        knxrif_pkg::REG_ROUTING_MODE: routing_mode      <= pwdata[1:0];
        knxrif_pkg::REG_OWN_ADDRESS:  own_address       <= pwdata[15:0];
        knxrif_pkg::REG_OWN_ADDR_VLD: own_address_valid <= pwdata[0];
        knxrif_pkg::REG_GROUP_WORD_0: group_word[0]     <= pwdata;
        knxrif_pkg::REG_GROUP_WORD_1: group_word[1]     <= pwdata;
        knxrif_pkg::REG_GROUP_WORD_2: group_word[2]     <= pwdata;
        knxrif_pkg::REG_GROUP_WORD_3: group_word[3]     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      knxrif_pkg::REG_ROUTING_MODE: prdata = {62'd0, routing_mode};
      knxrif_pkg::REG_OWN_ADDRESS:  prdata = {48'd0, own_address};
      knxrif_pkg::REG_OWN_ADDR_VLD: prdata = {63'd0, own_address_valid};
      knxrif_pkg::REG_GROUP_WORD_0: prdata = group_word[0];
      knxrif_pkg::REG_GROUP_WORD_1: prdata = group_word[1];
      knxrif_pkg::REG_GROUP_WORD_2: prdata = group_word[2];
      knxrif_pkg::REG_GROUP_WORD_3: prdata = group_word[3];
      default:                      prdata = '0;
    endcase
  end

  // ---------------- repeat tracking state ----------------
  logic [knxrif_pkg::ADDR_W-1:0] last_dest, last_dest_next;
  logic                          last_dest_individual, last_dest_individual_next;
  logic [RW-1:0]                 same_dest_run, same_dest_run_next;

  logic accept;
  logic skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // batch start wipes the tracking before the indication is looked at
  logic [knxrif_pkg::ADDR_W-1:0] base_dest;
  logic                          base_ind;
  logic [RW-1:0]                 base_run;
  logic                          same_hit;

  assign base_dest = batch_start ? '0   : last_dest;
  assign base_ind  = batch_start ? 1'b0 : last_dest_individual;
  assign base_run  = batch_start ? '0   : same_dest_run;
  assign same_hit  = !dest_is_group && base_ind && (base_dest == dest_address);

  always_comb begin
    last_dest_next            = base_dest;
    last_dest_individual_next = base_ind;
    same_dest_run_next        = base_run;
    if (frame_well_formed) begin
      if (same_hit) begin
        if (base_run < RW'(knxrif_pkg::SAME_DEST_LIMIT))
          same_dest_run_next = base_run + RW'(1);
      end else begin
        last_dest_next            = dest_address;
        last_dest_individual_next = !dest_is_group;
        same_dest_run_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_dest            <= '0;
      last_dest_individual <= 1'b0;
      same_dest_run        <= '0;
    end else if (accept) begin
      last_dest            <= last_dest_next;
      last_dest_individual <= last_dest_individual_next;
      same_dest_run        <= same_dest_run_next;
    end
  end

  // ---------------- action decision ----------------
  logic [255:0]        bitmap;
  logic                group_pass;
  knxrif_pkg::action_t hop_act, group_act, ind_act;
  logic [3:0]          d_area, d_line, o_area, o_line;
  logic [7:0]          d_dev;

  assign bitmap     = {group_word[3], group_word[2], group_word[1], group_word[0]};
  assign group_pass = bitmap[dest_address[15:8]];
  assign hop_act    = (hop_count != '0) ? knxrif_pkg::ACT_ROUTE_DECREMENTED
                                        : knxrif_pkg::ACT_IGNORE_ACKED;
  assign d_area = dest_address[15:12];
  assign d_line = dest_address[11:8];
  assign d_dev  = dest_address[7:0];
  assign o_area = own_address[15:12];
  assign o_line = own_address[11:8];

  always_comb begin
    case (routing_mode)
      knxrif_pkg::MODE_BLOCK_ALL: group_act = knxrif_pkg::ACT_IGNORE_TOTALLY;
      knxrif_pkg::MODE_FILTER:    group_act = group_pass ? hop_act
                                                         : knxrif_pkg::ACT_IGNORE_TOTALLY;
      default:                    group_act = hop_act;  // route all, and the unused code
    endcase
  end

  always_comb begin
    if (!own_address_valid) begin
      ind_act = knxrif_pkg::ACT_IGNORE_TOTALLY;
    end else if (o_line != '0) begin
      // line coupler
      if (d_area != o_area || d_line == o_line)
        ind_act = (d_dev == '0) ? knxrif_pkg::ACT_FORWARD_LOCALLY : hop_act;
      else
        ind_act = knxrif_pkg::ACT_IGNORE_TOTALLY;
    end else begin
      // area or backbone coupler
      if (d_area == o_area && d_line == '0 && d_dev == '0)
        ind_act = knxrif_pkg::ACT_FORWARD_LOCALLY;
      else
        ind_act = hop_act;
    end
  end

  knxrif_pkg::result_t res_next;

  always_comb begin
    res_next.action    = !frame_well_formed ? knxrif_pkg::ACT_IGNORE_TOTALLY
                       : dest_is_group       ? group_act : ind_act;
    res_next.malformed = !frame_well_formed;
    res_next.count     = same_dest_run_next;
    res_next.limit_hit = same_dest_run_next >= RW'(knxrif_pkg::SAME_DEST_LIMIT);
  end

  // ---------------- output register and skid slot ----------------
  knxrif_pkg::result_t out_res, skid_res;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res_next;
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign filter_action    = out_res.action;
  assign malformed        = out_res.malformed;
  assign repeat_count     = out_res.count;
  assign repeat_limit_hit = out_res.limit_hit;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while the output slot is empty");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    same_dest_run <= RW'(knxrif_pkg::SAME_DEST_LIMIT))
    else $error("repeat run exceeds its limit");

  a_malformed_ignored: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.malformed |-> out_res.action == knxrif_pkg::ACT_IGNORE_TOTALLY)
    else $error("malformed result carries a nonzero action");

  a_limit_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.limit_hit == (out_res.count >= RW'(knxrif_pkg::SAME_DEST_LIMIT)))
    else $error("limit flag disagrees with repeat count");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    accept && batch_start && !frame_well_formed
      |=> same_dest_run == '0 && !last_dest_individual)
    else $error("batch start on a malformed frame did not clear tracking");

endmodule
